/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with synchronous reset masking.
`define ASSERT_CLK(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Expression that must hold at every edge out of reset.
`define ASSERT_ALWAYS(lbl, ck, rs, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (expr)) else $error(msg);

`endif

/* hw/rtl/srb_pkg.sv */
// ----------------------------------------------------------------------------
// srb_pkg
// Types, codes and helpers for the sequence reorder buffer.
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam int SEQ_W   = 16;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 7;

  typedef logic [1:0]         op_t;
  typedef logic [1:0]         status_t;
  typedef logic [SEQ_W-1:0]   seq_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_LOOKUP = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  localparam status_t ST_DONE   = 2'd0;
  localparam status_t ST_RANGE  = 2'd1;
  localparam status_t ST_NOROOM = 2'd2;

  // serial-number order: a before b when the forward distance is the shorter
  function automatic logic seq_before(input seq_t a, input seq_t b);
    seq_t down;
    seq_t up;
    down = a - b;
    up   = b - a;
    return up < down;
  endfunction

endpackage

/* hw/rtl/srb_req_if.sv */
// ----------------------------------------------------------------------------
// srb_req_if
// Request channel: operation, sequence number and data word.
// ----------------------------------------------------------------------------
interface srb_req_if;
  logic             valid;
  logic             ready;
  srb_pkg::op_t     operation;
  srb_pkg::seq_t    seq_index;
  srb_pkg::word_t   entry_data;

  modport source (output valid, operation, seq_index, entry_data, input ready);
  modport sink   (input valid, operation, seq_index, entry_data, output ready);
endinterface

/* hw/rtl/srb_rsp_if.sv */
// ----------------------------------------------------------------------------
// srb_rsp_if
// Response channel: status, previous entry and window after the operation.
// ----------------------------------------------------------------------------
interface srb_rsp_if;
  logic              valid;
  logic              ready;
  srb_pkg::status_t  status;
  logic              had_entry;
  srb_pkg::word_t    entry_out;
  srb_pkg::seq_t     lowest_index;
  srb_pkg::seq_t     end_index;
  srb_pkg::count_t   occupied_count;

  modport source (output valid, status, had_entry, entry_out, lowest_index, end_index,
                  occupied_count, input ready);
  modport sink   (input valid, status, had_entry, entry_out, lowest_index, end_index,
                  occupied_count, output ready);
endinterface

/* hw/rtl/sequence_reorder_buffer_unit.sv */
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_unit
// Reorder window over 16-bit wrapping sequence numbers in circular storage.
// ----------------------------------------------------------------------------
// One request beat in, one response beat out. Insert and lookup pass through a
// memory read, then modify/write and result. A remove that drops the window
// start or the last held index steps through the slots one per cycle, through
// the single memory read port, until it meets an occupied slot. After reset a
// clearing pass writes every slot once before the first request is taken.
// The response sits in an output register, so the next request is taken while
// an earlier response still waits.
module sequence_reorder_buffer_unit #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  srb_req_if.sink     req,
  srb_rsp_if.source   rsp
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int KEEP_W = (DATA_WIDTH < srb_pkg::WORD_W) ? DATA_WIDTH : srb_pkg::WORD_W;
  localparam int MEM_W  = KEEP_W + 1;
  localparam logic [srb_pkg::SEQ_W:0] CAP_SEQ = (srb_pkg::SEQ_W + 1)'(CAPACITY);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SCANF  = 3'd3;
  localparam logic [2:0] S_SCANB  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  function automatic logic [SLOT_W-1:0] slot_of(input srb_pkg::seq_t s);
    return s[SLOT_W-1:0];
  endfunction

  // slot word: {occupied, data}
  logic [MEM_W-1:0]  mem [CAPACITY];
  logic [MEM_W-1:0]  rd_data;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [MEM_W-1:0]  wr_data;

  logic [2:0]        state, state_next;
  logic [SLOT_W-1:0] clr_addr;
  srb_pkg::op_t      op_q;
  srb_pkg::seq_t     seq_q;
  logic [KEEP_W-1:0] data_q;
  srb_pkg::seq_t     start, start_next;
  srb_pkg::seq_t     wend, wend_next;
  logic [CNT_W-1:0]  total, total_next;
  srb_pkg::seq_t     ptr, ptr_next;
  logic              bwd_pend, bwd_pend_next;
  srb_pkg::status_t  res_status, res_status_next;
  logic              res_had, res_had_next;
  srb_pkg::word_t    res_prev, res_prev_next;

  logic              finish;
  logic              out_free;
  logic              rd_occ;
  logic              ins_ok;
  logic              in_win;
  logic [CNT_W-1:0]  cnt_after;
  logic              fwd_scan;
  logic              bwd_scan;
  srb_pkg::seq_t     fwd_gap;
  srb_pkg::seq_t     seq_inc;
  srb_pkg::seq_t     seq_dec;

  assign req.ready = (state == S_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;
  assign rd_occ    = rd_data[MEM_W-1];
  assign fwd_gap   = seq_q - start;
  assign seq_inc   = seq_q + srb_pkg::seq_t'(1);
  assign seq_dec   = seq_q - srb_pkg::seq_t'(1);
  assign in_win    = !srb_pkg::seq_before(seq_q, start) && ({1'b0, fwd_gap} < CAP_SEQ);

  always_comb begin
    state_next      = state;
    start_next      = start;
    wend_next       = wend;
    total_next      = total;
    ptr_next        = ptr;
    bwd_pend_next   = bwd_pend;
    res_status_next = res_status;
    res_had_next    = res_had;
    res_prev_next   = res_prev;
    rd_en           = 1'b0;
    rd_addr         = slot_of(req.seq_index);
    wr_en           = 1'b0;
    wr_addr         = slot_of(seq_q);
    wr_data         = '0;
    finish          = 1'b0;
    ins_ok          = 1'b1;
    cnt_after       = total;
    fwd_scan        = 1'b0;
    bwd_scan        = 1'b0;

    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        if (clr_addr == LAST_SLOT) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          rd_en      = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        res_status_next = srb_pkg::ST_DONE;
        res_had_next    = 1'b0;
        res_prev_next   = '0;
        case (op_q)
          srb_pkg::OP_INSERT: begin
            finish = 1'b1;
            if (total == '0) begin
              start_next = seq_q;
              wend_next  = seq_inc;
            end else if (srb_pkg::seq_before(seq_q, start)) begin
              if ({1'b0, srb_pkg::seq_t'(wend - seq_q)} > CAP_SEQ) begin
                ins_ok = 1'b0;
              end else begin
                start_next = seq_q;
              end
            end else begin
              if ({1'b0, fwd_gap} >= CAP_SEQ) begin
                ins_ok = 1'b0;
              end else if (srb_pkg::seq_before(wend, seq_inc)) begin
                wend_next = seq_inc;
              end
            end
            if (!ins_ok) begin
              res_status_next = srb_pkg::ST_NOROOM;
            end else begin
              if (rd_occ) begin
                res_had_next  = 1'b1;
                res_prev_next = srb_pkg::WORD_W'(rd_data[KEEP_W-1:0]);
              end else begin
                total_next = total + CNT_W'(1);
              end
              wr_en   = 1'b1;
              wr_data = {1'b1, data_q};
            end
          end
          srb_pkg::OP_LOOKUP: begin
            finish = 1'b1;
            if (!in_win) begin
              res_status_next = srb_pkg::ST_RANGE;
            end else if (rd_occ) begin
              res_had_next  = 1'b1;
              res_prev_next = srb_pkg::WORD_W'(rd_data[KEEP_W-1:0]);
            end
          end
          srb_pkg::OP_REMOVE: begin
            if (!in_win) begin
              res_status_next = srb_pkg::ST_RANGE;
              finish          = 1'b1;
            end else begin
              if (rd_occ) begin
                cnt_after     = total - CNT_W'(1);
                res_had_next  = 1'b1;
                res_prev_next = srb_pkg::WORD_W'(rd_data[KEEP_W-1:0]);
                wr_en         = 1'b1;
                total_next    = cnt_after;
                if (cnt_after == '0) begin
                  wend_next = start;
                end
              end
              fwd_scan      = (seq_q == start) && (cnt_after != '0);
              bwd_scan      = (seq_inc == wend) && (cnt_after != '0);
              bwd_pend_next = bwd_scan;
              // the removed slot itself is known empty: step past it
              if (fwd_scan) begin
                ptr_next   = start + srb_pkg::seq_t'(1);
                rd_en      = 1'b1;
                rd_addr    = slot_of(ptr_next);
                state_next = S_SCANF;
              end else if (bwd_scan) begin
                ptr_next   = seq_dec;
                rd_en      = 1'b1;
                rd_addr    = slot_of(seq_dec);
                state_next = S_SCANB;
              end else begin
                finish = 1'b1;
              end
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      S_SCANF: begin
        if (rd_occ) begin
          start_next = ptr;
          if (bwd_pend) begin
            ptr_next   = seq_dec;
            rd_en      = 1'b1;
            rd_addr    = slot_of(seq_dec);
            state_next = S_SCANB;
          end else begin
            finish = 1'b1;
          end
        end else begin
          ptr_next = ptr + srb_pkg::seq_t'(1);
          rd_en    = 1'b1;
          rd_addr  = slot_of(ptr_next);
        end
      end
      S_SCANB: begin
        if (rd_occ) begin
          wend_next = ptr + srb_pkg::seq_t'(1);
          finish    = 1'b1;
        end else begin
          ptr_next = ptr - srb_pkg::seq_t'(1);
          rd_en    = 1'b1;
          rd_addr  = slot_of(ptr_next);
        end
      end
      S_FINISH: begin
        finish = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // hold the finished result until the output register frees up
    if (finish) begin
      state_next = out_free ? S_IDLE : S_FINISH;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      start    <= '0;
      wend     <= '0;
      total    <= '0;
      bwd_pend <= 1'b0;
    end else begin
      state    <= state_next;
      start    <= start_next;
      wend     <= wend_next;
      total    <= total_next;
      bwd_pend <= bwd_pend_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    res_status <= res_status_next;
    res_had    <= res_had_next;
    res_prev   <= res_prev_next;
    if (req.valid && req.ready) begin
      op_q   <= req.operation;
      seq_q  <= req.seq_index;
      data_q <= req.entry_data[KEEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (finish && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && out_free) begin
      rsp.status         <= res_status_next;
      rsp.had_entry      <= res_had_next;
      rsp.entry_out      <= res_prev_next;
      rsp.lowest_index   <= start_next;
      rsp.end_index      <= wend_next;
      rsp.occupied_count <= srb_pkg::COUNT_W'(total_next);
    end
  end

endmodule

/* hw/rtl/srb_checker.sv */
// ----------------------------------------------------------------------------
// srb_checker
// Port-level checks on the reorder buffer response stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srb_checker #(
  parameter int CAPACITY = 64
) (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input srb_pkg::status_t  status,
  input logic              had_entry,
  input srb_pkg::word_t    entry_out,
  input srb_pkg::seq_t     lowest_index,
  input srb_pkg::seq_t     end_index,
  input srb_pkg::count_t   occupied_count
);

  localparam logic [31:0] CAP_U = 32'(CAPACITY);
  localparam int PAYLOAD_W = $bits(srb_pkg::status_t) + 1 + $bits(srb_pkg::word_t) +
                             2 * $bits(srb_pkg::seq_t) + $bits(srb_pkg::count_t);

  logic                 stall;
  logic [PAYLOAD_W-1:0] payload;
  logic                 failed;
  logic                 no_entry;
  logic                 open_empty;
  logic                 over_cap;

  assign stall      = rsp_valid && !rsp_ready;
  assign payload    = {status, had_entry, entry_out, lowest_index, end_index, occupied_count};
  assign failed     = rsp_valid && (status != srb_pkg::ST_DONE);
  assign no_entry   = !had_entry && (entry_out == '0);
  assign open_empty = (occupied_count == '0) && (lowest_index != end_index);
  assign over_cap   = 32'(occupied_count) > CAP_U;

  // a stalled response beat keeps its payload
  `ASSERT_CLK(a_rsp_hold, clk, rst, stall |=> rsp_valid && $stable(payload), "stalled beat changed")

  // rejected or out-of-window operations report no entry
  `ASSERT_ALWAYS(a_no_entry, clk, rst, !failed || no_entry, "entry reported on failed operation")

  // an empty buffer has a collapsed window
  `ASSERT_ALWAYS(a_empty_win, clk, rst, !(rsp_valid && open_empty), "empty buffer with open window")

  // never more entries than slots
  `ASSERT_ALWAYS(a_count_cap, clk, rst, !(rsp_valid && over_cap), "occupied count above capacity")

endmodule

bind sequence_reorder_buffer_unit srb_checker #(.CAPACITY(CAPACITY)) u_srb_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .status         (rsp.status),
  .had_entry      (rsp.had_entry),
  .entry_out      (rsp.entry_out),
  .lowest_index   (rsp.lowest_index),
  .end_index      (rsp.end_index),
  .occupied_count (rsp.occupied_count)
);

/* tb/sv/srb_window_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srb_window_checker
// Watches the request and response channels of the reorder buffer. It keeps
// its own copy of the slot store and the window, works out the response for
// every accepted request beat and compares each response beat, in order, field
// by field.
// ----------------------------------------------------------------------------
module srb_window_checker #(
  parameter int SLOTS = 64
) (
  input  logic clk,
  input  logic rst,
  srb_req_if   req,
  srb_rsp_if   rsp,
  output int   errors,
  output int   outstanding,
  output int   checked,
  output int   noroom_seen,
  output int   range_seen,
  output int   peak_fill
);
  import srb_pkg::*;

  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    status_t status;
    logic    had_entry;
    word_t   entry_out;
    seq_t    lowest_index;
    seq_t    end_index;
    count_t  occupied_count;
  } rsp_beat_t;

  word_t     slot_word [SLOTS];
  logic      slot_held [SLOTS];
  seq_t      win_lo;
  seq_t      win_hi;
  int        held;
  rsp_beat_t pending_results [$];

  int err_count;
  int n_checked;
  int n_noroom;
  int n_range;
  int n_peak;

  // a is earlier than b when stepping forward from a to b is the shorter way
  function automatic logic seq_earlier(input seq_t a, input seq_t b);
    seq_t fwd;
    seq_t back;
    fwd  = b - a;
    back = a - b;
    return fwd < back;
  endfunction

  function automatic logic within_window(input seq_t s);
    seq_t gap;
    gap = s - win_lo;
    return !seq_earlier(s, win_lo) && (gap < SLOTS);
  endfunction

  function automatic rsp_beat_t apply_request(input op_t op, input seq_t s, input word_t data);
    rsp_beat_t r;
    logic [SLOT_W-1:0] k;
    seq_t nxt;
    seq_t gap;
    seq_t scan;
    logic ok;
    logic found;
    r     = '0;
    k     = s[SLOT_W-1:0];
    nxt   = s + 16'd1;
    ok    = 1'b1;
    found = 1'b0;
    case (op)
      OP_INSERT: begin
        if (held == 0) begin
          win_lo = s;
          win_hi = nxt;
        end else if (seq_earlier(s, win_lo)) begin
          gap = win_hi - s;
          if (gap > SLOTS) ok = 1'b0;
          else win_lo = s;
        end else begin
          gap = s - win_lo;
          if (gap >= SLOTS) ok = 1'b0;
          else if (seq_earlier(win_hi, nxt)) win_hi = nxt;
        end
        if (!ok) begin
          r.status = ST_NOROOM;
        end else begin
          if (slot_held[k]) begin
            r.had_entry = 1'b1;
            r.entry_out = slot_word[k];
          end else begin
            held++;
          end
          slot_word[k] = data;
          slot_held[k] = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (!within_window(s)) begin
          r.status = ST_RANGE;
        end else if (slot_held[k]) begin
          r.had_entry = 1'b1;
          r.entry_out = slot_word[k];
        end
      end
      OP_REMOVE: begin
        if (!within_window(s)) begin
          r.status = ST_RANGE;
        end else begin
          if (slot_held[k]) begin
            r.had_entry  = 1'b1;
            r.entry_out  = slot_word[k];
            slot_held[k] = 1'b0;
            held--;
            if (held == 0) win_hi = win_lo;
          end
          // dropped the first held index: walk forward to the next one
          if (s == win_lo && held != 0) begin
            scan = win_lo + 16'd1;
            for (int i = 0; i < SLOTS; i++) begin
              if (!found) begin
                if (slot_held[scan[SLOT_W-1:0]]) found = 1'b1;
                else scan = scan + 16'd1;
              end
            end
            win_lo = scan;
          end
          // dropped the last held index: walk back to the previous one
          found = 1'b0;
          if (nxt == win_hi && held != 0) begin
            scan = win_hi - 16'd1;
            for (int i = 0; i < SLOTS; i++) begin
              if (!found) begin
                if (slot_held[scan[SLOT_W-1:0]]) found = 1'b1;
                else scan = scan - 16'd1;
              end
            end
            win_hi = scan + 16'd1;
          end
        end
      end
      default: ;
    endcase
    r.lowest_index   = win_lo;
    r.end_index      = win_hi;
    r.occupied_count = count_t'(held);
    return r;
  endfunction

  function automatic string beat_str(input rsp_beat_t b);
    return $sformatf("status %0d had %0b word %08h lowest %04h end %04h count %0d",
                     b.status, b.had_entry, b.entry_out, b.lowest_index, b.end_index,
                     b.occupied_count);
  endfunction

  always @(posedge clk) begin : watch
    rsp_beat_t got;
    rsp_beat_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_held[i] = 1'b0;
      win_lo = '0;
      win_hi = '0;
      held   = 0;
      pending_results.delete();
      err_count = 0;
      n_checked = 0;
      n_noroom  = 0;
      n_range   = 0;
      n_peak    = 0;
    end else begin
      // a response can never belong to a request taken at the same edge
      if (rsp.valid && rsp.ready) begin
        got.status         = rsp.status;
        got.had_entry      = rsp.had_entry;
        got.entry_out      = rsp.entry_out;
        got.lowest_index   = rsp.lowest_index;
        got.end_index      = rsp.end_index;
        got.occupied_count = rsp.occupied_count;
        if (pending_results.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_LIMIT)
            $display("[%0t] response beat with nothing outstanding: %s", $time, beat_str(got));
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (want.status == ST_NOROOM) n_noroom++;
          if (want.status == ST_RANGE) n_range++;
          if (int'(want.occupied_count) > n_peak) n_peak = want.occupied_count;
          if (got.status !== want.status || got.had_entry !== want.had_entry ||
              got.entry_out !== want.entry_out || got.lowest_index !== want.lowest_index ||
              got.end_index !== want.end_index ||
              got.occupied_count !== want.occupied_count) begin
            err_count++;
            if (err_count <= REPORT_LIMIT) begin
              $display("[%0t] mismatch on response beat %0d", $time, n_checked);
              $display("  expected %s", beat_str(want));
              $display("  actual   %s", beat_str(got));
            end
          end
        end
      end
      if (req.valid && req.ready)
        pending_results.push_back(apply_request(req.operation, req.seq_index, req.entry_data));
    end
    errors      <= err_count;
    outstanding <= pending_results.size();
    checked     <= n_checked;
    noroom_seen <= n_noroom;
    range_seen  <= n_range;
    peak_fill   <= n_peak;
  end

endmodule

/* tb/sv/tb_sequence_reorder_buffer_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sequence_reorder_buffer_unit
// Drives the reorder buffer with a directed pass over the window edge cases,
// then random requests aimed around the live window, with bursty requests and
// a stalling response side. Checking is done by srb_window_checker.
// ----------------------------------------------------------------------------
module tb_sequence_reorder_buffer_unit;
  import srb_pkg::*;

  localparam int  CLK_PERIOD   = 20;
  localparam int  RESET_CYCLES = 10;
  localparam int  SLOTS        = 64;
  localparam int  RANDOM_ITEMS = 1000;
  localparam int  ROUND_ITEMS  = 80;
  localparam int  HOLD_AT      = 300;
  localparam int  PAUSE_AT     = 650;
  localparam int  LONG_HOLD    = 400;
  localparam int  DRAIN_CYCLES = 100;
  localparam int  IDLE_LIMIT   = 5000;
  localparam op_t OP_UNUSED    = 2'd3;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic clk;
  logic rst;

  srb_req_if req ();
  srb_rsp_if rsp ();

  int   errors;
  int   outstanding;
  int   checked;
  int   noroom_seen;
  int   range_seen;
  int   peak_fill;
  int   quiet_cycles;
  int   directed_sent;
  bit   hold_request;
  seq_t seen_lo;
  seq_t seen_hi;

  sequence_reorder_buffer_unit #(
    .CAPACITY   (SLOTS),
    .DATA_WIDTH (WORD_W)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  srb_window_checker #(
    .SLOTS (SLOTS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked),
    .noroom_seen (noroom_seen),
    .range_seen  (range_seen),
    .peak_fill   (peak_fill)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // last window reported back, used to aim requests
  always @(posedge clk) begin
    if (rst) begin
      seen_lo <= '0;
      seen_hi <= '0;
    end else if (rsp.valid && rsp.ready) begin
      seen_lo <= rsp.lowest_index;
      seen_hi <= rsp.end_index;
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_item(input op_t op, input seq_t s, input word_t data);
    req.valid      <= 1'b1;
    req.operation  <= op;
    req.seq_index  <= s;
    req.entry_data <= data;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    req.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // response side: stretches of open, coin-flip, sparse and mostly-open ready
  initial begin : receiver
    rx_mode_e mode;
    int span;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(10, 120);
      repeat (span) begin
        if (hold_request) begin
          hold_request = 1'b0;
          rsp.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          RX_OPEN:   rsp.ready <= 1'b1;
          RX_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: rsp.ready <= ($urandom_range(0, 7) == 0);
          default:   rsp.ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int   n;
    int   burst_left;
    int   insert_weight;
    int   pick;
    op_t  op;
    seq_t s;
    hold_request   = 1'b0;
    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.operation  <= OP_LOOKUP;
    req.seq_index  <= '0;
    req.entry_data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: empty buffer, window edges, half-range tie, scans, wrap at zero
    send_item(OP_LOOKUP, 16'h0000, 32'h0);
    send_item(OP_REMOVE, 16'h0005, 32'h0);
    send_item(OP_INSERT, 16'hFFFE, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 16'h0010, 32'h0000_0000);
    send_item(OP_INSERT, 16'hFFFE, 32'hA5A5_5A5A);
    send_item(OP_INSERT, 16'hFFC0, 32'h1234_5678);  // too far back
    send_item(OP_INSERT, 16'hFFD1, 32'h8765_4321);  // back by exactly full width
    send_item(OP_INSERT, 16'h0011, 32'h0F0F_0F0F);  // one past the end
    send_item(OP_INSERT, 16'h7FD1, 32'hF0F0_F0F0);  // half-range away
    send_item(OP_LOOKUP, 16'hFFD0, 32'h0);
    send_item(OP_LOOKUP, 16'h0011, 32'h0);
    send_item(OP_LOOKUP, 16'h0010, 32'h0);
    send_item(OP_REMOVE, 16'h0011, 32'h0);
    send_item(OP_REMOVE, 16'hFFD1, 32'h0);
    send_item(OP_REMOVE, 16'h0010, 32'h0);
    send_item(OP_UNUSED, 16'h5A5A, 32'hDEAD_BEEF);
    send_item(OP_REMOVE, 16'hFFFE, 32'h0);
    send_item(OP_REMOVE, 16'hFFFE, 32'h0);
    send_item(OP_INSERT, 16'hFFFF, 32'h0000_0001);
    send_item(OP_INSERT, 16'h0000, 32'h8000_0000);
    send_item(OP_REMOVE, 16'h0000, 32'h0);
    send_item(OP_LOOKUP, 16'hFFFF, 32'h0);
    directed_sent = 22;

    burst_left    = 0;
    insert_weight = 50;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % ROUND_ITEMS == 0) insert_weight = $urandom_range(20, 85);
      if (n == HOLD_AT) begin
        // keep offering beats while the response side holds off
        hold_request = 1'b1;
        burst_left   = 60;
      end
      if (n == PAUSE_AT) begin
        idle_cycles(1);
        while (outstanding != 0) @(posedge clk);
      end
      if (burst_left == 0) begin
        pick = $urandom_range(0, 12);
        if (pick != 0) idle_cycles(pick);
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;

      pick = $urandom_range(0, 99);
      if (pick < 3) op = OP_UNUSED;
      else if (pick < 3 + insert_weight) op = OP_INSERT;
      else if ($urandom_range(0, 2) == 0) op = OP_LOOKUP;
      else op = OP_REMOVE;

      case (op)
        OP_INSERT: begin
          pick = $urandom_range(0, 7);
          if (pick == 0) s = seen_hi;
          else if (pick == 1) s = seen_lo - seq_t'($urandom_range(1, 8));
          else s = seen_lo + seq_t'($urandom_range(0, 70));
        end
        OP_REMOVE: begin
          pick = $urandom_range(0, 3);
          if (pick == 0) s = seen_lo;
          else if (pick == 1) s = seen_hi - 16'd1;
          else if (pick == 2) s = seen_lo + seq_t'($urandom_range(0, 66));
          else s = seq_t'($urandom_range(0, 65535));
        end
        OP_LOOKUP: begin
          if ($urandom_range(0, 3) == 0) s = seq_t'($urandom_range(0, 65535));
          else s = seen_lo + seq_t'($urandom_range(0, 68)) - 16'd2;
        end
        default: s = seq_t'($urandom_range(0, 65535));
      endcase
      send_item(op, s, $urandom());
    end

    idle_cycles(1);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (outstanding != 0) $display("%0d responses never arrived", outstanding);
    $display("Checked %0d response beats from %0d directed and %0d random requests",
             checked, directed_sent, RANDOM_ITEMS);
    $display("Inserts refused for room %0d, requests outside window %0d, peak fill %0d of %0d",
             noroom_seen, range_seen, peak_fill, SLOTS);
    if (errors == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/srb_pkg.sv
hw/rtl/srb_req_if.sv
hw/rtl/srb_rsp_if.sv
hw/rtl/sequence_reorder_buffer_unit.sv
hw/rtl/srb_checker.sv
tb/sv/srb_window_checker.sv
tb/sv/tb_sequence_reorder_buffer_unit.sv
